### hdl/ptfp_pkg.sv
// Package for the padded tile fetch planner.
// Shared types, codes and default sizes; no dependencies.
`default_nettype none

package ptfp_pkg;

  // fixed widths of the configuration registers
  localparam int SIZE_W     = 15;
  localparam int ORG_W      = 16;
  localparam int CFG_DATA_W = 16;
  localparam int CFG_ADDR_W = 3;
  localparam int KIND_W     = 3;
  localparam int MODE_W     = 3;
  localparam int STATE_W    = 5;

  // parameter defaults
  localparam int DEF_MAX_OPS     = 16;
  localparam int DEF_STACK_DEPTH = 8;
  localparam int DEF_COORD_BITS  = 16;

  // configuration register indexes
  localparam logic [CFG_ADDR_W-1:0] REG_SRC_WIDTH     = 3'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_SRC_HEIGHT    = 3'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_ORIGIN_X      = 3'd2;
  localparam logic [CFG_ADDR_W-1:0] REG_ORIGIN_Y      = 3'd3;
  localparam logic [CFG_ADDR_W-1:0] REG_CANVAS_WIDTH  = 3'd4;
  localparam logic [CFG_ADDR_W-1:0] REG_CANVAS_HEIGHT = 3'd5;
  localparam logic [CFG_ADDR_W-1:0] REG_CANVAS_WRAP   = 3'd6;
  localparam logic [CFG_ADDR_W-1:0] REG_BORDER_MODES  = 3'd7;

  // border mode codes
  localparam logic [MODE_W-1:0] MODE_EXTEND    = 3'd2;
  localparam logic [MODE_W-1:0] MODE_EXTEND_ZA = 3'd3;
  localparam logic [MODE_W-1:0] MODE_WRAP      = 3'd4;

  typedef enum logic [KIND_W-1:0] {
    KIND_COPY     = 3'd0,
    KIND_CONST_H  = 3'd1,
    KIND_CONST_V  = 3'd2,
    KIND_PAD      = 3'd3,
    KIND_PAD_EDGE = 3'd4
  } op_kind_t;

  typedef enum logic [STATE_W-1:0] {
    S_IDLE, S_ENTRY,
    S_CX, S_CX_DIV, S_CX_SPLIT,
    S_CY, S_CY_DIV, S_CY_SPLIT,
    S_SRC,
    S_HX, S_HX_DIV, S_HX_HI, S_HX_LO,
    S_VY, S_VY_DIV, S_VY_HI, S_VY_LO,
    S_FINAL, S_RET, S_POP, S_FLUSH
  } state_t;

  // sequencer to output buffer strobes
  typedef struct packed {
    logic emit;
    logic flush;
  } emit_ctl_t;

endpackage

`default_nettype wire

### hdl/ptfp_div.sv
// Shared wrap unit: floor(a/d)*d by a restoring remainder loop, one bit per cycle.
// Does not use ptfp_pkg; standalone arithmetic.
`default_nettype none

module ptfp_div #(
  parameter int IW = 22,
  parameter int DW = 15
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 start,
  input  wire logic signed [IW-1:0] a,
  input  wire logic [DW-1:0]        dv,
  output logic                      done,
  output logic signed [IW-1:0]      m
);
  localparam int CW = $clog2(IW + 1);

  logic              run_r;
  logic              done_r;
  logic [CW-1:0]     cnt_r;
  logic [IW-1:0]     mag_r;
  logic [DW-1:0]     rem_r;
  logic [DW-1:0]     d_r;
  logic signed [IW-1:0] a_r;
  logic              neg_r;
  logic signed [IW-1:0] m_r;

  logic [DW:0]       trial;
  logic [DW:0]       diff;
  logic [DW-1:0]     rem_step;
  logic signed [IW-1:0] remx;
  logic signed [IW-1:0] dx;
  logic signed [IW-1:0] m_calc;

  // one remainder step
  assign trial    = {rem_r, mag_r[IW-1]};
  assign diff     = trial - {1'b0, d_r};
  assign rem_step = (trial >= {1'b0, d_r}) ? diff[DW-1:0] : trial[DW-1:0];

  // floor multiple from the remainder of |a|
  assign remx   = {{(IW-DW){1'b0}}, rem_r};
  assign dx     = {{(IW-DW){1'b0}}, d_r};
  assign m_calc = !neg_r ? (a_r - remx) :
                  ((rem_r == '0) ? a_r : (a_r + remx - dx));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        run_r <= 1'b1;
        cnt_r <= '0;
      end else if (run_r) begin
        if (cnt_r != CW'(IW)) begin
          cnt_r <= cnt_r + 1'b1;
        end else begin
          run_r  <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (start) begin
      a_r   <= a;
      d_r   <= dv;
      neg_r <= a[IW-1];
      mag_r <= a[IW-1] ? (-a) : a;
      rem_r <= '0;
    end else if (run_r) begin
      if (cnt_r != CW'(IW)) begin
        rem_r <= rem_step;
        mag_r <= {mag_r[IW-2:0], 1'b0};
      end else begin
        m_r <= m_calc;
      end
    end
  end

  assign done = done_r;
  assign m    = m_r;

endmodule

`default_nettype wire

### hdl/ptfp_stack.sv
// Frame stack for split pieces: parents saved while a child is planned.
// Registered read port; depends on nothing else.
`default_nettype none

module ptfp_stack #(
  parameter int DEPTH = 8,
  parameter int FW    = 125
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [FW-1:0]            wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [FW-1:0]                 rd_data
);
  logic [FW-1:0] mem [DEPTH];
  logic [FW-1:0] rd_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_r;

endmodule

`default_nettype wire

### hdl/ptfp_emit_buf.sv
// Output side: holds the newest operation back one slot so the final one gets tlast.
// Uses ptfp_pkg (emit_ctl_t).
`default_nettype none

module ptfp_emit_buf #(
  parameter int OPW   = 163,
  parameter int OUT_W = 168
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire ptfp_pkg::emit_ctl_t ctl,
  input  wire logic [OPW-1:0]      op,
  output logic                     ok,
  output logic                     out_tvalid,
  input  wire logic                out_tready,
  output logic [OUT_W-1:0]         out_tdata,
  output logic                     out_tlast
);
  import ptfp_pkg::*;

  logic           pv_r, ov_r, last_r;
  logic [OPW-1:0] pend_r, data_r;
  logic           out_free;

  assign out_free = !ov_r || out_tready;
  assign ok       = !pv_r || out_free;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pv_r <= 1'b0;
      ov_r <= 1'b0;
    end else begin
      if (ctl.emit) begin
        pv_r <= 1'b1;
        if (pv_r) begin
          ov_r <= 1'b1;
        end else if (out_tready) begin
          ov_r <= 1'b0;
        end
      end else if (ctl.flush) begin
        pv_r <= 1'b0;
        ov_r <= 1'b1;
      end else if (out_tready) begin
        ov_r <= 1'b0;
      end
    end
  end

  // payload: pending slot and output register
  always_ff @(posedge clk) begin
    if (ctl.emit) begin
      pend_r <= op;
      if (pv_r) begin
        data_r <= pend_r;
        last_r <= 1'b0;
      end
    end else if (ctl.flush) begin
      data_r <= pend_r;
      last_r <= 1'b1;
    end
  end

  assign out_tvalid = ov_r;
  assign out_tdata  = {{(OUT_W-OPW){1'b0}}, data_r};
  assign out_tlast  = last_r;

endmodule

`default_nettype wire

### hdl/ptfp_seq.sv
// Planning sequencer: walks the split tree depth-first, drives the wrap unit,
// the frame stack and the output buffer. Uses ptfp_pkg.
`default_nettype none

module ptfp_seq #(
  parameter int MAX_OPS     = ptfp_pkg::DEF_MAX_OPS,
  parameter int STACK_DEPTH = ptfp_pkg::DEF_STACK_DEPTH,
  parameter int COORD_BITS  = ptfp_pkg::DEF_COORD_BITS,
  parameter int IW          = 22,
  parameter int FW          = 125,
  parameter int OPW         = 163
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            start,
  output logic                                 idle,
  input  wire logic [COORD_BITS-1:0]           req_left,
  input  wire logic [COORD_BITS-1:0]           req_top,
  input  wire logic [COORD_BITS-1:0]           req_right,
  input  wire logic [COORD_BITS-1:0]           req_bottom,
  input  wire logic [COORD_BITS-1:0]           dest_x,
  input  wire logic [COORD_BITS-1:0]           dest_y,
  input  wire logic [ptfp_pkg::SIZE_W-1:0]     src_width,
  input  wire logic [ptfp_pkg::SIZE_W-1:0]     src_height,
  input  wire logic [ptfp_pkg::ORG_W-1:0]      origin_x,
  input  wire logic [ptfp_pkg::ORG_W-1:0]      origin_y,
  input  wire logic [ptfp_pkg::SIZE_W-1:0]     canvas_width,
  input  wire logic [ptfp_pkg::SIZE_W-1:0]     canvas_height,
  input  wire logic [1:0]                      canvas_wrap,
  input  wire logic [2*ptfp_pkg::MODE_W-1:0]   border_modes,
  output logic                                 div_start,
  output logic signed [IW-1:0]                 div_a,
  output logic [ptfp_pkg::SIZE_W-1:0]          div_dv,
  input  wire logic                            div_done,
  input  wire logic signed [IW-1:0]            div_m,
  output logic                                 push_en,
  output logic [$clog2(STACK_DEPTH)-1:0]       push_addr,
  output logic [FW-1:0]                        push_data,
  output logic                                 rd_en,
  output logic [$clog2(STACK_DEPTH)-1:0]       rd_addr,
  input  wire logic [FW-1:0]                   rd_data,
  output ptfp_pkg::emit_ctl_t                  ectl,
  output logic [OPW-1:0]                       op,
  input  wire logic                            emit_ok
);
  import ptfp_pkg::*;

  localparam int CB   = COORD_BITS;
  localparam int SPW  = $clog2(STACK_DEPTH);
  localparam int CNTW = $clog2(MAX_OPS + 1);

  typedef logic signed [IW-1:0] crd_t;

  state_t             state_r, state_nxt;
  crd_t               bl_r, bt_r, br_r, bb_r;
  crd_t               bl_nxt, bt_nxt, br_nxt, bb_nxt;
  logic [CB-1:0]      dx_r, dy_r, dx_nxt, dy_nxt;
  logic [SPW-1:0]     sp_r, sp_nxt;
  logic [CNTW-1:0]    cnt_r, cnt_nxt;

  // configuration seen as wide signed values
  crd_t ox, oy, w_i, h_i, cw_i, ch_i, fr, fb;
  logic [MODE_W-1:0] hm, vm;

  assign ox   = {{(IW-ORG_W){origin_x[ORG_W-1]}}, origin_x};
  assign oy   = {{(IW-ORG_W){origin_y[ORG_W-1]}}, origin_y};
  assign w_i  = {{(IW-SIZE_W){1'b0}}, src_width};
  assign h_i  = {{(IW-SIZE_W){1'b0}}, src_height};
  assign cw_i = {{(IW-SIZE_W){1'b0}}, canvas_width};
  assign ch_i = {{(IW-SIZE_W){1'b0}}, canvas_height};
  assign fr   = ox + w_i;
  assign fb   = oy + h_i;
  assign hm   = border_modes[MODE_W-1:0];
  assign vm   = border_modes[2*MODE_W-1:MODE_W];

  // stack depth check
  logic deeper;
  assign deeper = {1'b0, sp_r} < (SPW+1)'(STACK_DEPTH - 1);

  // entry: piece lies wholly inside the image (or is the all-zero box)
  logic box_zero, ent_copy;
  assign box_zero = (bl_r == '0) && (bt_r == '0) && (br_r == '0) && (bb_r == '0);
  assign ent_copy = box_zero ||
                    ((bl_r >= ox) && (bt_r >= oy) && (br_r <= fr) && (bb_r <= fb) &&
                     (br_r > bl_r) && (bb_r > bt_r));

  // overlap with the image on the canvas
  crd_t mx_l, mx_t, mn_r, mn_b;
  logic inter_full;
  assign mx_l = (bl_r > ox) ? bl_r : ox;
  assign mx_t = (bt_r > oy) ? bt_r : oy;
  assign mn_r = (br_r < fr) ? br_r : fr;
  assign mn_b = (bb_r < fb) ? bb_r : fb;
  assign inter_full = (mn_r > mx_l) && (mn_b > mx_t);

  // canvas wrap split conditions
  logic cxa, cxb, cya, cyb;
  assign cxa = inter_full && (bl_r < ox) && (br_r <= fr) && ((bl_r + cw_i) < fr);
  assign cxb = inter_full && (br_r > fr) && (bl_r >= ox) && ((br_r - cw_i) > ox);
  assign cya = inter_full && (bt_r < oy) && (bb_r <= fb) && ((bt_r + ch_i) < fb);
  assign cyb = inter_full && (bb_r > fb) && (bt_r >= oy) && ((bb_r - ch_i) > oy);

  // offset deltas
  crd_t g_ox_l, g_fr_l, g_oy_t, g_fb_t, g_w_l, g_h_t;
  assign g_ox_l = ox - bl_r;
  assign g_fr_l = fr - bl_r;
  assign g_oy_t = oy - bt_r;
  assign g_fb_t = fb - bt_r;
  assign g_w_l  = w_i - bl_r;
  assign g_h_t  = h_i - bt_r;

  // split selection: child piece, updated parent, resume point
  logic          sp_take;
  crd_t          ch_l, ch_t, ch_r, ch_b, pa_l, pa_t, pa_r, pa_b;
  logic [CB-1:0] ch_dx, ch_dy, pa_dx, pa_dy;
  state_t        resume;

  always_comb begin
    sp_take = 1'b0;
    ch_l = bl_r; ch_t = bt_r; ch_r = br_r; ch_b = bb_r;
    pa_l = bl_r; pa_t = bt_r; pa_r = br_r; pa_b = bb_r;
    ch_dx = dx_r; ch_dy = dy_r; pa_dx = dx_r; pa_dy = dy_r;
    resume = S_IDLE;
    case (state_r)
      S_CX_SPLIT: begin
        resume = S_CY;
        if (cxa) begin
          sp_take = 1'b1;
          ch_l  = bl_r + cw_i;
          ch_r  = ox + cw_i;
          pa_dx = dx_r + g_ox_l[CB-1:0];
          pa_l  = ox;
        end else if (cxb) begin
          sp_take = 1'b1;
          ch_l  = fr - cw_i;
          ch_r  = br_r - cw_i;
          ch_dx = dx_r + g_fr_l[CB-1:0];
          pa_r  = fr;
        end
      end
      S_CY_SPLIT: begin
        resume = S_SRC;
        if (cya) begin
          sp_take = 1'b1;
          ch_t  = bt_r + ch_i;
          ch_b  = oy + ch_i;
          pa_dy = dy_r + g_oy_t[CB-1:0];
          pa_t  = oy;
        end else if (cyb) begin
          sp_take = 1'b1;
          ch_t  = fb - ch_i;
          ch_b  = bb_r - ch_i;
          ch_dy = dy_r + g_fb_t[CB-1:0];
          pa_b  = fb;
        end
      end
      S_HX_HI: begin
        resume = S_HX_LO;
        ch_l = w_i + ox; ch_t = bt_r + oy; ch_r = br_r + ox; ch_b = bb_r + oy;
        ch_dx = dx_r + g_w_l[CB-1:0];
        pa_r  = w_i;
        sp_take = br_r > w_i;
      end
      S_HX_LO: begin
        resume = S_VY;
        ch_l = bl_r + ox; ch_t = bt_r + oy; ch_r = ox; ch_b = bb_r + oy;
        pa_dx = dx_r - bl_r[CB-1:0];
        pa_l  = '0;
        sp_take = bl_r < 0;
      end
      S_VY_HI: begin
        resume = S_VY_LO;
        ch_l = bl_r + ox; ch_t = h_i + oy; ch_r = br_r + ox; ch_b = bb_r + oy;
        ch_dy = dy_r + g_h_t[CB-1:0];
        pa_b  = h_i;
        sp_take = bb_r > h_i;
      end
      S_VY_LO: begin
        resume = S_FINAL;
        ch_l = bl_r + ox; ch_t = bt_r + oy; ch_r = br_r + ox; ch_b = oy;
        pa_dy = dy_r - bt_r[CB-1:0];
        pa_t  = '0;
        sp_take = bt_r < 0;
      end
      default: begin
        sp_take = 1'b0;
      end
    endcase
  end

  // final classification against the image rectangle
  crd_t al, at, ar, ab, wdt, hgt;
  logic av_empty, src_eq, h_const, v_const;
  assign al  = (bl_r > 0) ? bl_r : '0;
  assign at  = (bt_r > 0) ? bt_r : '0;
  assign ar  = (br_r < w_i) ? br_r : w_i;
  assign ab  = (bb_r < h_i) ? bb_r : h_i;
  assign wdt = br_r - bl_r;
  assign hgt = bb_r - bt_r;
  assign av_empty = (ar <= al) || (ab <= at);
  assign src_eq = box_zero ||
                  ((bl_r >= 0) && (bt_r >= 0) && (br_r <= w_i) && (bb_r <= h_i) &&
                   (br_r > bl_r) && (bb_r > bt_r));
  assign h_const = (hm != MODE_EXTEND) && (hm != MODE_EXTEND_ZA) &&
                   ((br_r <= 0) || (bl_r >= w_i) || (w_i == '0));
  assign v_const = (vm != MODE_EXTEND) && (vm != MODE_EXTEND_ZA) &&
                   ((bb_r <= 0) || (bt_r >= h_i) || (h_i == '0));

  // operation fields
  logic [CB-1:0] o_l, o_t, o_r, o_b;
  crd_t          rd_l, rd_t, rd_r, rd_b, wr_x, wr_y;
  op_kind_t      kind;

  assign o_l = dx_r;
  assign o_t = dy_r;
  assign o_r = dx_r + wdt[CB-1:0];
  assign o_b = dy_r + hgt[CB-1:0];

  always_comb begin
    kind = KIND_COPY;
    rd_l = bl_r; rd_t = bt_r; rd_r = br_r; rd_b = bb_r;
    wr_x = '0; wr_y = '0;
    if (state_r == S_ENTRY) begin
      rd_l = bl_r - ox; rd_t = bt_r - oy; rd_r = br_r - ox; rd_b = bb_r - oy;
    end else if (src_eq) begin
      kind = KIND_COPY;
    end else if (!av_empty) begin
      kind = KIND_PAD;
      rd_l = al; rd_t = at; rd_r = ar; rd_b = ab;
      wr_x = al - bl_r;
      wr_y = at - bt_r;
    end else if (h_const) begin
      kind = KIND_CONST_H;
      rd_l = '0; rd_t = '0; rd_r = '0; rd_b = '0;
    end else if (v_const) begin
      kind = KIND_CONST_V;
      rd_l = '0; rd_t = '0; rd_r = '0; rd_b = '0;
    end else begin
      kind = KIND_PAD_EDGE;
      // nearest column
      if (br_r <= 0) begin
        rd_l = '0; rd_r = crd_t'(1); wr_x = wdt - crd_t'(1);
      end else if (bl_r >= w_i) begin
        rd_l = w_i - crd_t'(1); rd_r = w_i; wr_x = '0;
      end else begin
        rd_l = al; rd_r = ar; wr_x = al - bl_r;
      end
      // nearest row
      if (bb_r <= 0) begin
        rd_t = '0; rd_b = crd_t'(1); wr_y = hgt - crd_t'(1);
      end else if (bt_r >= h_i) begin
        rd_t = h_i - crd_t'(1); rd_b = h_i; wr_y = '0;
      end else begin
        rd_t = at; rd_b = ab; wr_y = at - bt_r;
      end
    end
  end

  assign op = {wr_y[CB-1:0], wr_x[CB-1:0], rd_b[CB-1:0], rd_r[CB-1:0], rd_t[CB-1:0],
               rd_l[CB-1:0], o_b, o_r, o_t, o_l, kind};

  // emission gating
  logic emit_need, emit_room, emit_go;
  assign emit_need = ((state_r == S_ENTRY) && ent_copy) || (state_r == S_FINAL);
  assign emit_room = cnt_r < CNTW'(MAX_OPS);
  assign emit_go   = !emit_room || emit_ok;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE:     state_nxt = start ? S_ENTRY : S_IDLE;
      S_ENTRY:    state_nxt = ent_copy ? (emit_go ? S_RET : S_ENTRY) : S_CX;
      S_CX: begin
        if (canvas_wrap[0]) begin
          state_nxt = (canvas_width != '0) ? S_CX_DIV : S_CX_SPLIT;
        end else begin
          state_nxt = S_CY;
        end
      end
      S_CX_DIV:   state_nxt = div_done ? S_CX_SPLIT : S_CX_DIV;
      S_CY: begin
        if (canvas_wrap[1]) begin
          state_nxt = (canvas_height != '0) ? S_CY_DIV : S_CY_SPLIT;
        end else begin
          state_nxt = S_SRC;
        end
      end
      S_CY_DIV:   state_nxt = div_done ? S_CY_SPLIT : S_CY_DIV;
      S_SRC:      state_nxt = S_HX;
      S_HX: begin
        if (hm == MODE_WRAP) begin
          state_nxt = (src_width != '0) ? S_HX_DIV : S_HX_HI;
        end else begin
          state_nxt = S_VY;
        end
      end
      S_HX_DIV:   state_nxt = div_done ? S_HX_HI : S_HX_DIV;
      S_VY: begin
        if (vm == MODE_WRAP) begin
          state_nxt = (src_height != '0) ? S_VY_DIV : S_VY_HI;
        end else begin
          state_nxt = S_FINAL;
        end
      end
      S_VY_DIV:   state_nxt = div_done ? S_VY_HI : S_VY_DIV;
      S_CX_SPLIT, S_CY_SPLIT, S_HX_HI, S_HX_LO, S_VY_HI, S_VY_LO: begin
        state_nxt = (sp_take && deeper) ? S_ENTRY : resume;
      end
      S_FINAL:    state_nxt = emit_go ? S_RET : S_FINAL;
      S_RET:      state_nxt = (sp_r == '0) ? S_FLUSH : S_POP;
      S_POP:      state_nxt = state_t'(rd_data[FW-1 -: STATE_W]);
      S_FLUSH:    state_nxt = emit_ok ? S_IDLE : S_FLUSH;
      default:    state_nxt = S_IDLE;
    endcase
  end

  // datapath and strobes
  always_comb begin
    bl_nxt = bl_r; bt_nxt = bt_r; br_nxt = br_r; bb_nxt = bb_r;
    dx_nxt = dx_r; dy_nxt = dy_r;
    sp_nxt = sp_r;
    cnt_nxt = cnt_r;
    div_start = 1'b0;
    div_a = '0;
    div_dv = '0;
    push_en = 1'b0;
    push_addr = sp_r;
    push_data = {resume, pa_dy, pa_dx, pa_b, pa_r, pa_t, pa_l};
    rd_en = 1'b0;
    rd_addr = sp_r - 1'b1;
    ectl.emit = emit_need && emit_room && emit_ok;
    ectl.flush = 1'b0;
    if (ectl.emit) begin
      cnt_nxt = cnt_r + 1'b1;
    end
    case (state_r)
      S_IDLE: begin
        if (start) begin
          bl_nxt = {{(IW-CB){req_left[CB-1]}}, req_left};
          bt_nxt = {{(IW-CB){req_top[CB-1]}}, req_top};
          br_nxt = {{(IW-CB){req_right[CB-1]}}, req_right};
          bb_nxt = {{(IW-CB){req_bottom[CB-1]}}, req_bottom};
          dx_nxt = dest_x;
          dy_nxt = dest_y;
          sp_nxt = '0;
          cnt_nxt = '0;
        end
      end
      S_CX: begin
        div_start = canvas_wrap[0] && (canvas_width != '0);
        div_a  = br_r - crd_t'(1) - ox;
        div_dv = canvas_width;
      end
      S_CY: begin
        div_start = canvas_wrap[1] && (canvas_height != '0);
        div_a  = bb_r - crd_t'(1) - oy;
        div_dv = canvas_height;
      end
      S_HX: begin
        div_start = (hm == MODE_WRAP) && (src_width != '0);
        div_a  = br_r - crd_t'(1);
        div_dv = src_width;
      end
      S_VY: begin
        div_start = (vm == MODE_WRAP) && (src_height != '0);
        div_a  = bb_r - crd_t'(1);
        div_dv = src_height;
      end
      S_CX_DIV, S_HX_DIV: begin
        if (div_done) begin
          bl_nxt = bl_r - div_m;
          br_nxt = br_r - div_m;
        end
      end
      S_CY_DIV, S_VY_DIV: begin
        if (div_done) begin
          bt_nxt = bt_r - div_m;
          bb_nxt = bb_r - div_m;
        end
      end
      S_SRC: begin
        bl_nxt = bl_r - ox; bt_nxt = bt_r - oy;
        br_nxt = br_r - ox; bb_nxt = bb_r - oy;
      end
      S_CX_SPLIT, S_CY_SPLIT, S_HX_HI, S_HX_LO, S_VY_HI, S_VY_LO: begin
        if (sp_take && deeper) begin
          // save the updated parent, descend into the split-off piece
          push_en = 1'b1;
          bl_nxt = ch_l; bt_nxt = ch_t; br_nxt = ch_r; bb_nxt = ch_b;
          dx_nxt = ch_dx; dy_nxt = ch_dy;
          sp_nxt = sp_r + 1'b1;
        end else if (sp_take) begin
          // too deep: piece dropped, parent still trimmed
          bl_nxt = pa_l; bt_nxt = pa_t; br_nxt = pa_r; bb_nxt = pa_b;
          dx_nxt = pa_dx; dy_nxt = pa_dy;
        end
      end
      S_RET: begin
        rd_en = (sp_r != '0);
      end
      S_POP: begin
        bl_nxt = rd_data[IW-1:0];
        bt_nxt = rd_data[2*IW-1:IW];
        br_nxt = rd_data[3*IW-1:2*IW];
        bb_nxt = rd_data[4*IW-1:3*IW];
        dx_nxt = rd_data[4*IW+CB-1:4*IW];
        dy_nxt = rd_data[4*IW+2*CB-1:4*IW+CB];
        sp_nxt = sp_r - 1'b1;
      end
      S_FLUSH: begin
        ectl.flush = emit_ok;
      end
      default: begin
        sp_nxt = sp_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      sp_r    <= '0;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      sp_r    <= sp_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  // working frame
  always_ff @(posedge clk) begin
    bl_r <= bl_nxt;
    bt_r <= bt_nxt;
    br_r <= br_nxt;
    bb_r <= bb_nxt;
    dx_r <= dx_nxt;
    dy_r <= dy_nxt;
  end

  assign idle = (state_r == S_IDLE);

endmodule

`default_nettype wire

### hdl/padded_tile_fetch_planner.sv
// Top level of the padded tile fetch planner: configuration registers and wiring
// of sequencer, wrap unit, frame stack and output buffer. Uses ptfp_pkg.
//
//  channel | dir | handshake             | content
//  in_     | in  | in_tvalid/in_tready   | request rectangle and destination offset
//  out_    | out | out_tvalid/out_tready | one fetch-and-pad operation, tlast on final
//  cfg_    | in  | cfg_we                | register write, index cfg_addr
//
//  A request is taken only while the planner is idle and occupies it until its
//  final operation is queued. Each planned piece walks the sequencer from entry
//  through the final classification to return (entry and return only when it is
//  copied whole at entry); every wrap it takes (x/y canvas, x/y image) adds a wait
//  on the one shared remainder unit, one quotient bit per cycle, and split steps;
//  an operation is held one slot so tlast can be set. Output stalls freeze the
//  sequencer at its next emit. Reset is synchronous; no clearing pass.
`default_nettype none

module padded_tile_fetch_planner #(
  parameter int MAX_OPS     = ptfp_pkg::DEF_MAX_OPS,
  parameter int STACK_DEPTH = ptfp_pkg::DEF_STACK_DEPTH,
  parameter int COORD_BITS  = ptfp_pkg::DEF_COORD_BITS
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  // req_left, req_top, req_right, req_bottom, dest_x, dest_y
  input  wire logic [((6*COORD_BITS+7)/8)*8-1:0]   in_tdata,
  input  wire logic                                in_tvalid,
  output logic                                     in_tready,
  // op_kind, out_left, out_top, out_right, out_bottom, read_left, read_top,
  // read_right, read_bottom, write_x, write_y
  output logic [((ptfp_pkg::KIND_W+10*COORD_BITS+7)/8)*8-1:0] out_tdata,
  output logic                                     out_tvalid,
  input  wire logic                                out_tready,
  output logic                                     out_tlast,
  input  wire logic                                cfg_we,
  input  wire logic [ptfp_pkg::CFG_ADDR_W-1:0]     cfg_addr,
  input  wire logic [ptfp_pkg::CFG_DATA_W-1:0]     cfg_wdata
);
  import ptfp_pkg::*;

  localparam int CB    = COORD_BITS;
  localparam int IW    = ((CB > ORG_W) ? CB : ORG_W) + 6;
  localparam int FW    = STATE_W + 2*CB + 4*IW;
  localparam int OPW   = KIND_W + 10*CB;
  localparam int OUT_W = ((OPW + 7) / 8) * 8;
  localparam int SPW   = $clog2(STACK_DEPTH);

  // configuration registers
  logic [SIZE_W-1:0]   srcw_r, srch_r, canw_r, canh_r;
  logic [ORG_W-1:0]    orgx_r, orgy_r;
  logic [1:0]          wrap_r;
  logic [2*MODE_W-1:0] modes_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      srcw_r  <= '0;
      srch_r  <= '0;
      orgx_r  <= '0;
      orgy_r  <= '0;
      canw_r  <= SIZE_W'(1);
      canh_r  <= SIZE_W'(1);
      wrap_r  <= '0;
      modes_r <= '0;
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_SRC_WIDTH:     srcw_r  <= cfg_wdata[SIZE_W-1:0];
        REG_SRC_HEIGHT:    srch_r  <= cfg_wdata[SIZE_W-1:0];
        REG_ORIGIN_X:      orgx_r  <= cfg_wdata[ORG_W-1:0];
        REG_ORIGIN_Y:      orgy_r  <= cfg_wdata[ORG_W-1:0];
        REG_CANVAS_WIDTH:  canw_r  <= cfg_wdata[SIZE_W-1:0];
        REG_CANVAS_HEIGHT: canh_r  <= cfg_wdata[SIZE_W-1:0];
        REG_CANVAS_WRAP:   wrap_r  <= cfg_wdata[1:0];
        REG_BORDER_MODES:  modes_r <= cfg_wdata[2*MODE_W-1:0];
        default:           modes_r <= modes_r;
      endcase
    end
  end

  logic                 idle, start;
  logic                 div_start, div_done;
  logic signed [IW-1:0] div_a, div_m;
  logic [SIZE_W-1:0]    div_dv;
  logic                 push_en, rd_en;
  logic [SPW-1:0]       push_addr, rd_addr;
  logic [FW-1:0]        push_data, rd_data;
  emit_ctl_t            ectl;
  logic [OPW-1:0]       op;
  logic                 emit_ok;

  assign in_tready = idle;
  assign start     = in_tvalid && idle;

  ptfp_seq #(
    .MAX_OPS(MAX_OPS), .STACK_DEPTH(STACK_DEPTH), .COORD_BITS(COORD_BITS),
    .IW(IW), .FW(FW), .OPW(OPW)
  ) u_seq (
    .clk(clk), .rst_n(rst_n), .start(start), .idle(idle),
    .req_left(in_tdata[0*CB +: CB]), .req_top(in_tdata[1*CB +: CB]),
    .req_right(in_tdata[2*CB +: CB]), .req_bottom(in_tdata[3*CB +: CB]),
    .dest_x(in_tdata[4*CB +: CB]), .dest_y(in_tdata[5*CB +: CB]),
    .src_width(srcw_r), .src_height(srch_r), .origin_x(orgx_r), .origin_y(orgy_r),
    .canvas_width(canw_r), .canvas_height(canh_r), .canvas_wrap(wrap_r),
    .border_modes(modes_r),
    .div_start(div_start), .div_a(div_a), .div_dv(div_dv),
    .div_done(div_done), .div_m(div_m),
    .push_en(push_en), .push_addr(push_addr), .push_data(push_data),
    .rd_en(rd_en), .rd_addr(rd_addr), .rd_data(rd_data),
    .ectl(ectl), .op(op), .emit_ok(emit_ok)
  );

  ptfp_div #(.IW(IW), .DW(SIZE_W)) u_div (
    .clk(clk), .rst_n(rst_n), .start(div_start), .a(div_a), .dv(div_dv),
    .done(div_done), .m(div_m)
  );

  ptfp_stack #(.DEPTH(STACK_DEPTH), .FW(FW)) u_stack (
    .clk(clk), .wr_en(push_en), .wr_addr(push_addr), .wr_data(push_data),
    .rd_en(rd_en), .rd_addr(rd_addr), .rd_data(rd_data)
  );

  ptfp_emit_buf #(.OPW(OPW), .OUT_W(OUT_W)) u_emit (
    .clk(clk), .rst_n(rst_n), .ctl(ectl), .op(op), .ok(emit_ok),
    .out_tvalid(out_tvalid), .out_tready(out_tready),
    .out_tdata(out_tdata), .out_tlast(out_tlast)
  );

endmodule

`default_nettype wire
